// File: src/itg_pkg.sv
// ----------------------------------------------------------------------------
// itg_pkg: shared types, constants and the sine table for the I/Q tone source
// Holds the channel payload structs, register codes and the elaborated table.
// ----------------------------------------------------------------------------
package itg_pkg;

	localparam int TBL_BITS    = 10;
	localparam int TBL_SIZE    = 1 << TBL_BITS;
	localparam int TBL_QUARTER = 1 << (TBL_BITS - 2);

	localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
	localparam logic [29:0]     NS_PER_SEC = 30'd1000000000;

	localparam int CFG_W     = 34;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_PHASE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NS_WHOLE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NS_FRAC     = 3'd5;

	localparam logic [1:0] OP_GENERATE = 2'd0;
	localparam logic [1:0] OP_EPOCH    = 2'd1;
	localparam logic [1:0] OP_SKIP     = 2'd2;

	localparam int DIV_W = 49;

	typedef struct packed {
		logic [1:0]  operation;
		logic [47:0] skip_count;
	} itg_cmd_t;

	typedef struct packed {
		logic signed [15:0] i_sample;
		logic signed [15:0] q_sample;
		logic               i_clipped;
		logic               q_clipped;
		logic [62:0]        timestamp_ns;
	} itg_smp_t;

	typedef logic signed [17:0] sine_rom_t [TBL_SIZE];

	typedef struct packed {
		logic signed [15:0] value;
		logic               clipped;
	} itg_scaled_t;

	// Long division by compare and subtract, used only while the table elaborates.
	function automatic longint unsigned series_div(longint unsigned num,
			longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Quarter-wave sine by Taylor series in Q30, rounded to Q16.
	function automatic logic [16:0] quarter_sine(int unsigned j);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned r;
		longint          sum;
		x = (TWO_PI_Q30 * longint'(j) + longint'(TBL_SIZE >> 1)) >> TBL_BITS;
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		for (int n = 1; n <= 7; n++) begin
			term = series_div((term * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
			if (n % 2 == 1) sum = sum - longint'(term);
			else sum = sum + longint'(term);
		end
		if (sum < 0) sum = 0;
		r = (longint'(sum) + 64'd8192) >> 14;
		if (r > 64'd65536) r = 64'd65536;
		return r[16:0];
	endfunction

	function automatic sine_rom_t build_rom();
		sine_rom_t   rom;
		int unsigned q;
		int unsigned j;
		logic [16:0] v;
		for (int k = 0; k < TBL_SIZE; k++) begin
			q = k / TBL_QUARTER;
			j = k % TBL_QUARTER;
			v = (q % 2 == 1) ? quarter_sine(TBL_QUARTER - j) : quarter_sine(j);
			rom[k] = (q >= 2) ? -$signed({1'b0, v}) : $signed({1'b0, v});
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_rom();

	// Round half away from zero by 2^24 and saturate to 16 bits.
	function automatic itg_scaled_t scale_product(logic signed [52:0] prod);
		itg_scaled_t res;
		logic [52:0] mag;
		logic [52:0] rnd;
		if (prod > 53'sd549739036672) begin
			res.value = 16'sh7fff;
			res.clipped = 1'b1;
		end else if (prod < -53'sd549755813888) begin
			res.value = -16'sh8000;
			res.clipped = 1'b1;
		end else begin
			mag = prod[52] ? 53'(-prod) : 53'(prod);
			rnd = (mag + 53'd8388608) >> 24;
			res.value = prod[52] ? -$signed(rnd[15:0]) : $signed(rnd[15:0]);
			res.clipped = 1'b0;
		end
		return res;
	endfunction

endpackage

// File: src/itg_div.sv
// ----------------------------------------------------------------------------
// itg_div: restoring divider, one quotient bit per cycle
// Divides a 49-bit dividend by a 21-bit nonzero divisor; done pulses at the end.
// ----------------------------------------------------------------------------
module itg_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [itg_pkg::DIV_W-1:0] dividend,
	input  logic [20:0]               divisor,
	output logic                      done,
	output logic [itg_pkg::DIV_W-1:0] quotient,
	output logic [20:0]               remainder
);
	import itg_pkg::*;

	localparam int CNT_W = $clog2(DIV_W);

	logic [DIV_W-1:0] quo_q;
	logic [20:0]      rem_q;
	logic [20:0]      div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [21:0]      trial;
	logic             fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= fits ? 21'(trial - {1'b0, div_q}) : trial[20:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// File: src/iq_tone_generator_core.sv
// ----------------------------------------------------------------------------
// iq_tone_generator_core: complex tone source with timestamped I/Q samples
// Phase accumulator, sine table memory, amplitude scaling and time counters.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  cmd     | in        | cmd_valid/cmd_stall | itg_cmd_t (operation, skip_count)
//  smp     | out       | smp_valid/smp_stall | itg_smp_t (I, Q, clip flags, time)
//  cfg     | in        | cfg_we              | cfg_index, cfg_data
//
// A generate runs through accept with the table read, multiply and the output
// register. Begin-epoch completes at acceptance. A skip makes two passes through
// the bit-serial divider and then a three-step timestamp multiply; with a zero
// sample rate it goes straight to the timestamp multiply.
// The block takes one item at a time; a stalled sample holds in the output
// register and the last stage waits for it. Reset restores the control and
// state registers; the data pipeline registers are not reset.
module iq_tone_generator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  itg_pkg::itg_cmd_t             cmd,
	output logic                          smp_valid,
	input  logic                          smp_stall,
	output itg_pkg::itg_smp_t             smp,
	input  logic                          cfg_we,
	input  logic [itg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [itg_pkg::CFG_W-1:0]     cfg_data
);
	import itg_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_OUT  = 3'd2;
	localparam logic [2:0] S_DIV1 = 3'd3;
	localparam logic [2:0] S_DIV2 = 3'd4;
	localparam logic [2:0] S_TS   = 3'd5;

	logic [2:0] state_q;

	logic [31:0] phase_step_q;
	logic [33:0] amp_q;
	logic [31:0] start_phase_q;
	logic [20:0] rate_q;
	logic [19:0] ns_whole_q;
	logic [20:0] ns_frac_q;

	logic [31:0] phase_q;
	logic [43:0] ws_q;
	logic [20:0] sis_q;
	logic [29:0] ns_q;
	logic [20:0] nsrem_q;
	logic [31:0] clip_cnt_q;
	logic [63:0] sec_ns_q;

	logic signed [17:0] rom_c_s1;
	logic signed [17:0] rom_s_s1;
	logic [63:0]        ts_s1;
	logic signed [52:0] prod_i_s2;
	logic signed [52:0] prod_q_s2;
	logic [63:0]        ts_s2;
	logic               smp_valid_q;
	itg_smp_t           smp_q;

	logic [40:0] ns_prod_q;
	logic [1:0]  ts_k_q;
	logic [63:0] ts_acc_q;

	logic [TBL_BITS-1:0] idx;
	logic [TBL_BITS-1:0] cidx;
	logic                accept;
	logic                out_free;

	logic             div_start;
	logic [DIV_W-1:0] div_dividend;
	logic             div_done;
	logic [DIV_W-1:0] div_quo;
	logic [20:0]      div_rem;

	logic [20:0] sis_n;
	logic [29:0] ns_n;
	logic [20:0] rem_n;
	logic [14:0] ws_chunk;
	logic [63:0] ts_term;
	itg_scaled_t sc_i;
	itg_scaled_t sc_q;

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = state_q != S_IDLE;
	assign out_free  = !smp_valid_q || !smp_stall;
	assign idx       = phase_q[31 -: TBL_BITS];
	assign cidx      = idx + TBL_BITS'(TBL_QUARTER);

	// Sine table memory, two registered read ports.
	always_ff @(posedge clk) begin
		rom_c_s1 <= SINE_ROM[cidx];
		rom_s_s1 <= SINE_ROM[idx];
	end

	always_comb begin
		sis_n = sis_q + 21'd1;
		ns_n  = ns_q + 30'(ns_whole_q);
		rem_n = nsrem_q + ns_frac_q;
		if (rem_n >= rate_q) begin
			rem_n = rem_n - rate_q;
			ns_n  = ns_n + 30'd1;
		end
	end

	always_comb begin
		case (ts_k_q)
			2'd0:    ws_chunk = ws_q[14:0];
			2'd1:    ws_chunk = ws_q[29:15];
			default: ws_chunk = {1'b0, ws_q[43:30]};
		endcase
		ts_term = 64'(45'(ws_chunk) * 45'(NS_PER_SEC)) << (15 * ts_k_q);
	end

	assign sc_i = scale_product(prod_i_s2);
	assign sc_q = scale_product(prod_q_s2);

	always_comb begin
		div_start    = 1'b0;
		div_dividend = 49'(sis_q) + 49'(cmd.skip_count);
		if (state_q == S_IDLE) begin
			div_start = accept && cmd.operation == OP_SKIP && rate_q != '0;
		end else if (state_q == S_DIV1) begin
			div_start    = div_done;
			div_dividend = 49'(div_rem * ns_frac_q);
		end
	end

	itg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (rate_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q  <= '0;
			amp_q         <= '0;
			start_phase_q <= '0;
			rate_q        <= 21'd1000;
			ns_whole_q    <= 20'd1000000;
			ns_frac_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PHASE_STEP:  phase_step_q  <= cfg_data[31:0];
				REG_AMPLITUDE:   amp_q         <= cfg_data;
				REG_START_PHASE: start_phase_q <= cfg_data[31:0];
				REG_SAMPLE_RATE: rate_q        <= cfg_data[20:0];
				REG_NS_WHOLE:    ns_whole_q    <= cfg_data[19:0];
				REG_NS_FRAC:     ns_frac_q     <= cfg_data[20:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= '0;
			ws_q        <= '0;
			sis_q       <= '0;
			ns_q        <= '0;
			nsrem_q     <= '0;
			clip_cnt_q  <= '0;
			sec_ns_q    <= '0;
			smp_valid_q <= 1'b0;
			ts_k_q      <= '0;
			ts_acc_q    <= '0;
		end else begin
			if (smp_valid_q && !smp_stall && state_q != S_OUT) smp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd.operation)
							OP_GENERATE: begin
								state_q <= S_MUL;
								phase_q <= phase_q + phase_step_q;
								if (sis_n >= rate_q) begin
									ws_q     <= ws_q + 44'd1;
									sec_ns_q <= (&ws_q) ? '0 : sec_ns_q + 64'(NS_PER_SEC);
									sis_q    <= '0;
									ns_q     <= '0;
									nsrem_q  <= '0;
								end else begin
									sis_q   <= sis_n;
									ns_q    <= ns_n;
									nsrem_q <= rem_n;
								end
							end
							OP_EPOCH: begin
								phase_q  <= start_phase_q;
								ws_q     <= '0;
								sis_q    <= '0;
								ns_q     <= '0;
								nsrem_q  <= '0;
								sec_ns_q <= '0;
							end
							OP_SKIP: begin
								phase_q <= phase_q + 32'(phase_step_q * cmd.skip_count[31:0]);
								if (rate_q == '0) begin
									ws_q     <= ws_q + cmd.skip_count[43:0];
									sis_q    <= '0;
									ns_q     <= '0;
									nsrem_q  <= '0;
									ts_k_q   <= '0;
									ts_acc_q <= '0;
									state_q  <= S_TS;
								end else begin
									state_q <= S_DIV1;
								end
							end
							default: ;
						endcase
					end
				end
				S_MUL: state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						smp_valid_q <= 1'b1;
						clip_cnt_q  <= clip_cnt_q + 32'(sc_i.clipped) + 32'(sc_q.clipped);
						state_q     <= S_IDLE;
					end else begin
						smp_valid_q <= 1'b1;
					end
				end
				S_DIV1: begin
					if (div_done) begin
						ws_q      <= ws_q + div_quo[43:0];
						sis_q     <= div_rem;
						ns_prod_q <= div_rem * ns_whole_q;
						state_q   <= S_DIV2;
					end
				end
				S_DIV2: begin
					if (div_done) begin
						ns_q     <= 30'(ns_prod_q + 41'(div_quo));
						nsrem_q  <= div_rem;
						ts_k_q   <= '0;
						ts_acc_q <= '0;
						state_q  <= S_TS;
					end
				end
				S_TS: begin
					// Rebuild whole_seconds * 1e9 in three 15-bit slices.
					ts_acc_q <= ts_acc_q + ts_term;
					ts_k_q   <= ts_k_q + 2'd1;
					if (ts_k_q == 2'd2) begin
						sec_ns_q <= ts_acc_q + ts_term;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) ts_s1 <= sec_ns_q + 64'(ns_q);
		if (state_q == S_MUL) begin
			prod_i_s2 <= $signed({1'b0, amp_q}) * rom_c_s1;
			prod_q_s2 <= $signed({1'b0, amp_q}) * rom_s_s1;
			ts_s2     <= ts_s1;
		end
		if (state_q == S_OUT && out_free) begin
			smp_q.i_sample     <= sc_i.value;
			smp_q.q_sample     <= sc_q.value;
			smp_q.i_clipped    <= sc_i.clipped;
			smp_q.q_clipped    <= sc_q.clipped;
			smp_q.timestamp_ns <= ts_s2[62:0];
		end
	end

	assign smp_valid = smp_valid_q;
	assign smp       = smp_q;

endmodule

// File: src/itg_checker.sv
// ----------------------------------------------------------------------------
// itg_checker: port-level checks for the I/Q tone source
// Watches the sample channel and the command handshake over time.
// ----------------------------------------------------------------------------
module itg_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_stall,
	input itg_pkg::itg_cmd_t cmd,
	input logic              smp_valid,
	input logic              smp_stall,
	input itg_pkg::itg_smp_t smp
);
	import itg_pkg::*;

	a_smp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && smp_stall |=> smp_valid && $stable(smp))
		else $error("stalled sample changed");

	a_i_clip: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && smp.i_clipped |->
			smp.i_sample == 16'sh7fff || smp.i_sample == -16'sh8000)
		else $error("in-phase clip flag without saturated value");

	a_q_clip: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && smp.q_clipped |->
			smp.q_sample == 16'sh7fff || smp.q_sample == -16'sh8000)
		else $error("quadrature clip flag without saturated value");

	a_gen_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && cmd.operation == OP_GENERATE |=> cmd_stall)
		else $error("generate transfer did not hold off the next command");

endmodule

bind iq_tone_generator_core itg_checker u_itg_checker (.*);
